// File: design/jsu_pkg.sv
// Shared types and constants for the JSON string unescape unit.
package jsu_pkg;

    localparam int RUN_MAX = 6;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [2:0]              count;
        logic                    data;
        logic                    ended;
    } run_t;

endpackage

// File: design/jsu_front.sv
// Front end: escape decoder that turns one text word into a run of output bytes.
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    input  logic       string_start,
    input  logic       text_end,
    input  logic       full,
    output logic       push,
    output run_t       push_run
);

    typedef enum logic [2:0] {
        P_IDLE,
        P_TEXT,
        P_ESC,
        P_HEX,
        P_PEND_BS,
        P_PEND_U,
        P_PEND_HEX
    } phase_t;

    typedef enum logic [1:0] {
        SEC_NONE,
        SEC_LIT,
        SEC_BMP,
        SEC_SUP
    } sec_t;

    localparam logic [7:0]  CH_BSLASH = 8'h5C;
    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_N      = 8'h6E;
    localparam logic [7:0]  CH_R      = 8'h72;
    localparam logic [7:0]  CH_T      = 8'h74;
    localparam logic [7:0]  CH_U      = 8'h75;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_TAB    = 8'h09;
    localparam logic [15:0] HI_FIRST  = 16'hD800;
    localparam logic [15:0] HI_LAST   = 16'hDBFF;
    localparam logic [15:0] LO_FIRST  = 16'hDC00;
    localparam logic [15:0] LO_LAST   = 16'hDFFF;
    localparam logic [20:0] SUP_BASE  = 21'h10000;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic logic [3:0][7:0] enc_bmp(input logic [15:0] v);
        logic [3:0][7:0] b;
        b = '0;
        if (v < 16'h0080)
        begin
            b[0] = v[7:0];
        end
        else if (v < 16'h0800)
        begin
            b[0] = {3'b110, v[10:6]};
            b[1] = {2'b10, v[5:0]};
        end
        else
        begin
            b[0] = {4'b1110, v[15:12]};
            b[1] = {2'b10, v[11:6]};
            b[2] = {2'b10, v[5:0]};
        end
        return b;
    endfunction

    function automatic logic [2:0] bmp_len(input logic [15:0] v);
        logic [2:0] n;
        if (v < 16'h0080)
        begin
            n = 3'd1;
        end
        else if (v < 16'h0800)
        begin
            n = 3'd2;
        end
        else
        begin
            n = 3'd3;
        end
        return n;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] pend_reg, pend_next;

    phase_t          phase_eff;
    logic [15:0]     acc_eff;
    logic [1:0]      cnt_eff;
    logic [15:0]     pend_eff;
    logic [15:0]     acc_shift;
    logic            digit_done;
    logic            flush_old;
    logic            do_plain;
    logic            do_esc;
    logic            do_fin;
    logic            ended;
    sec_t            sec_kind;
    logic [7:0]      sec_lit;
    logic [15:0]     sec_val;
    logic [20:0]     sup_cp;
    logic [3:0][7:0] sec_bytes;
    logic [2:0]      sec_len;
    logic [3:0][7:0] old_bytes;
    logic            accept;

    assign text_stall = full;
    assign accept     = text_valid && !full;

    always_comb
    begin
        phase_eff = string_start ? P_TEXT : phase_reg;
        acc_eff   = string_start ? 16'd0 : acc_reg;
        cnt_eff   = string_start ? 2'd0 : cnt_reg;
        pend_eff  = string_start ? 16'd0 : pend_reg;

        acc_shift  = {acc_eff[11:0], hex_value(text_byte)};
        digit_done = (cnt_eff == 2'd3);
        sup_cp     = {1'b0, pend_eff[9:0], acc_shift[9:0]} + SUP_BASE;

        phase_next = phase_eff;
        acc_next   = acc_eff;
        cnt_next   = cnt_eff;
        pend_next  = pend_eff;
        flush_old  = 1'b0;
        do_plain   = 1'b0;
        do_esc     = 1'b0;
        do_fin     = 1'b0;
        ended      = 1'b0;
        sec_kind   = SEC_NONE;
        sec_lit    = text_byte;
        sec_val    = acc_shift;

        unique case (phase_eff)
            P_IDLE:
            begin
                phase_next = P_IDLE;
            end
            P_TEXT:
            begin
                do_plain = 1'b1;
            end
            P_ESC:
            begin
                do_esc = 1'b1;
            end
            P_HEX:
            begin
                acc_next = acc_shift;
                cnt_next = cnt_eff + 2'd1;
                do_fin   = digit_done;
            end
            P_PEND_BS:
            begin
                if (text_byte == CH_BSLASH)
                begin
                    phase_next = P_PEND_U;
                end
                else
                begin
                    flush_old = 1'b1;
                    do_plain  = 1'b1;
                end
            end
            P_PEND_U:
            begin
                if (text_byte == CH_U)
                begin
                    acc_next   = 16'd0;
                    cnt_next   = 2'd0;
                    phase_next = P_PEND_HEX;
                end
                else
                begin
                    flush_old = 1'b1;
                    do_esc    = 1'b1;
                end
            end
            P_PEND_HEX:
            begin
                acc_next = acc_shift;
                cnt_next = cnt_eff + 2'd1;
                if (digit_done)
                begin
                    if (acc_shift >= LO_FIRST && acc_shift <= LO_LAST)
                    begin
                        sec_kind   = SEC_SUP;
                        pend_next  = 16'd0;
                        phase_next = P_TEXT;
                    end
                    else
                    begin
                        flush_old = 1'b1;
                        do_fin    = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase

        if (do_plain)
        begin
            phase_next = P_TEXT;
            if (text_byte == CH_BSLASH)
            begin
                phase_next = P_ESC;
            end
            else if (text_byte == CH_QUOTE)
            begin
                ended = 1'b1;
            end
            else
            begin
                sec_kind = SEC_LIT;
            end
        end

        if (do_esc)
        begin
            phase_next = P_TEXT;
            sec_kind   = SEC_LIT;
            unique case (text_byte)
                CH_N:    sec_lit = CH_LF;
                CH_R:    sec_lit = CH_CR;
                CH_T:    sec_lit = CH_TAB;
                CH_U:
                begin
                    acc_next   = 16'd0;
                    cnt_next   = 2'd0;
                    phase_next = P_HEX;
                    sec_kind   = SEC_NONE;
                end
                default: sec_lit = text_byte;
            endcase
        end

        if (do_fin)
        begin
            if (acc_shift >= HI_FIRST && acc_shift <= HI_LAST)
            begin
                pend_next  = acc_shift;
                phase_next = P_PEND_BS;
            end
            else
            begin
                sec_kind   = SEC_BMP;
                sec_val    = acc_shift;
                phase_next = P_TEXT;
            end
        end

        // flush a waiting high surrogate at the end of the text
        if (phase_eff != P_IDLE && !ended && text_end)
        begin
            if (phase_next == P_PEND_BS || phase_next == P_PEND_U
                || phase_next == P_PEND_HEX)
            begin
                sec_kind = SEC_BMP;
                sec_val  = pend_next;
            end
            ended = 1'b1;
        end

        if (ended)
        begin
            phase_next = P_IDLE;
            acc_next   = 16'd0;
            cnt_next   = 2'd0;
            pend_next  = 16'd0;
        end
    end

    always_comb
    begin
        sec_bytes = '0;
        sec_len   = 3'd0;
        case (sec_kind)
            SEC_LIT:
            begin
                sec_bytes[0] = sec_lit;
                sec_len      = 3'd1;
            end
            SEC_BMP:
            begin
                sec_bytes = enc_bmp(sec_val);
                sec_len   = bmp_len(sec_val);
            end
            SEC_SUP:
            begin
                sec_bytes[0] = {5'b11110, sup_cp[20:18]};
                sec_bytes[1] = {2'b10, sup_cp[17:12]};
                sec_bytes[2] = {2'b10, sup_cp[11:6]};
                sec_bytes[3] = {2'b10, sup_cp[5:0]};
                sec_len      = 3'd4;
            end
            default:
            begin
                sec_len = 3'd0;
            end
        endcase

        old_bytes      = enc_bmp(pend_eff);
        push_run       = '0;
        push_run.ended = ended;
        if (flush_old)
        begin
            push_run.bytes[0] = old_bytes[0];
            push_run.bytes[1] = old_bytes[1];
            push_run.bytes[2] = old_bytes[2];
            push_run.bytes[3] = sec_bytes[0];
            push_run.bytes[4] = sec_bytes[1];
            push_run.bytes[5] = sec_bytes[2];
            push_run.count    = sec_len + 3'd3;
        end
        else
        begin
            push_run.bytes[0] = sec_bytes[0];
            push_run.bytes[1] = sec_bytes[1];
            push_run.bytes[2] = sec_bytes[2];
            push_run.bytes[3] = sec_bytes[3];
            push_run.count    = sec_len;
        end
        push_run.data = (push_run.count != 3'd0);
        if (ended && push_run.count == 3'd0)
        begin
            push_run.count = 3'd1;
        end
    end

    assign push = accept && (push_run.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            acc_reg   <= 16'd0;
            cnt_reg   <= 2'd0;
            pend_reg  <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// File: design/jsu_run_fifo.sv
// Run queue between the decoder and the output serializer.
module jsu_run_fifo
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_run,
    output logic full,
    input  logic pop,
    output run_t head,
    output logic head_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    run_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (fill_reg == CW'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

// File: design/jsu_back.sv
// Back end: serializes queued runs into registered result words.
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  run_t       head,
    input  logic       head_valid,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_end,
    output logic       last_of_run
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       data_reg;
    logic       end_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;

    assign load    = head_valid && (!valid_reg || !result_stall);
    assign is_last = (idx_reg == head.count - 3'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.bytes[idx_reg];
            data_reg <= head.data;
            end_reg  <= head.ended && is_last;
            last_reg <= is_last;
        end
    end

    assign result_valid = valid_reg;
    assign out_byte     = byte_reg;
    assign byte_valid   = data_reg;
    assign string_end   = end_reg;
    assign last_of_run  = last_reg;

endmodule

// File: design/json_string_unescape_to_utf8_unit.sv
// JSON string unescape to UTF-8: top level tying decoder, run queue and serializer.
// The first result word of a text word is registered in the run queue and then in the
// result register before it is valid.
// Throughput: one text word per cycle while the result side keeps up; a text word that
// yields n bytes takes one result word per byte, so the output serializer sets the rate.
// The run queue (QUEUE_DEPTH runs) lets the decoder run ahead while results drain.
// Reset: rst_n clears the decoder to outside-any-string and empties the queue at once.
module json_string_unescape_to_utf8_unit
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    input  logic       string_start,
    input  logic       text_end,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_end,
    output logic       last_of_run
);

    logic full;
    logic push;
    run_t push_run;
    logic pop;
    run_t head;
    logic head_valid;

    jsu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .string_start (string_start),
        .text_end     (text_end),
        .full         (full),
        .push         (push),
        .push_run     (push_run)
    );

    jsu_run_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    jsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .string_end   (string_end),
        .last_of_run  (last_of_run)
    );

endmodule

// File: design/jsu_checker.sv
// Port-level assertions for the JSON string unescape unit, with its bind.
module jsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       string_end,
    input logic       last_of_run
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && string_end |-> last_of_run)
        else $error("string end not on last word of run");

    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_valid |-> out_byte == 8'd0 && string_end && last_of_run)
        else $error("malformed bare end marker");

    a_marker_alone: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_run |-> byte_valid)
        else $error("bare marker inside a run");

endmodule

bind json_string_unescape_to_utf8_unit jsu_checker u_chk (.*);
